FILE: src/i2cram_pkg.sv
// Shared types and constants of the I2C register access master.
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

    localparam int MAX_BYTES = 8;

    // Phase length after reset, in timebase ticks
    localparam logic [15:0] TICKS_RESET = 16'd6;

    // Request action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_ST2  = 5'd3,
        PH_ST3  = 5'd4,
        PH_TXA  = 5'd5,
        PH_TXB  = 5'd6,
        PH_TXC  = 5'd7,
        PH_TKA  = 5'd8,
        PH_TKB  = 5'd9,
        PH_TKC  = 5'd10,
        PH_RXA  = 5'd11,
        PH_RXB  = 5'd12,
        PH_RXC  = 5'd13,
        PH_RKA  = 5'd14,
        PH_RKB  = 5'd15,
        PH_RKC  = 5'd16,
        PH_RKD  = 5'd17,
        PH_SP0  = 5'd18,
        PH_SP1  = 5'd19,
        PH_SP2  = 5'd20,
        PH_SP3  = 5'd21
    } t_phase;

    typedef struct packed {
        t_phase       phase;
        logic [15:0]  tick;
        logic [2:0]   bit_pos;
        logic [3:0]   byte_pos;
        logic [7:0]   shreg;
        logic         read_mode;
        logic         ok;
        logic [7:0]   addr;
        logic [7:0]   index;
        logic [63:0]  data;
        logic [3:0]   count;
        logic         scl;
        logic         sda;
        logic         drv;
    } t_core_state;

    typedef struct packed {
        logic [1:0]   action;
        logic [7:0]   device_address;
        logic [7:0]   register_index;
        logic [3:0]   byte_count;
        logic [63:0]  write_data;
        logic         sda_in;
    } t_request;

    typedef struct packed {
        logic         scl_level;
        logic         sda_level;
        logic         sda_drive;
        logic         busy_res;
        logic [7:0]   read_byte;
        logic         read_valid;
        logic         done_res;
        logic         success;
    } t_result;

endpackage

`default_nettype wire

FILE: src/i2cram_step.sv
// Next-state and result logic of the I2C pin sequencer for one request.
`timescale 1ns / 1ps
`default_nettype none

module i2cram_step (
    input  wire i2cram_pkg::t_core_state i_state,
    input  wire i2cram_pkg::t_request    i_req,
    input  wire logic [15:0]             i_ticks,
    output i2cram_pkg::t_core_state      o_next,
    output i2cram_pkg::t_result          o_result
);

    // Set the pins for the phase being entered
    function automatic i2cram_pkg::t_core_state enter(input i2cram_pkg::t_core_state st,
                                                      input i2cram_pkg::t_phase ph);
        i2cram_pkg::t_core_state s;
        s = st;
        s.phase = ph;
        case (ph)
            i2cram_pkg::PH_ST0: begin s.drv = 1'b1; s.sda = 1'b1; end
            i2cram_pkg::PH_ST1: s.scl = 1'b1;
            i2cram_pkg::PH_ST2: s.sda = 1'b0;
            i2cram_pkg::PH_ST3: s.scl = 1'b0;
            i2cram_pkg::PH_TXA: s.scl = 1'b0;
            i2cram_pkg::PH_TXB: s.sda = s.shreg[s.bit_pos];
            i2cram_pkg::PH_TXC: s.scl = 1'b1;
            i2cram_pkg::PH_TKA: begin s.drv = 1'b0; s.scl = 1'b0; end
            i2cram_pkg::PH_TKB: s.scl = 1'b1;
            i2cram_pkg::PH_TKC: s.scl = 1'b0;
            i2cram_pkg::PH_RXA: begin s.drv = 1'b0; s.scl = 1'b0; end
            i2cram_pkg::PH_RXB: s.scl = 1'b1;
            i2cram_pkg::PH_RKA: s.scl = 1'b0;
            i2cram_pkg::PH_RKB: begin
                s.drv = 1'b1;
                // NAK the last byte, ACK the others
                s.sda = (({1'b0, s.byte_pos} + 5'd1) >= {1'b0, s.count});
            end
            i2cram_pkg::PH_RKC: s.scl = 1'b1;
            i2cram_pkg::PH_RKD: s.scl = 1'b0;
            i2cram_pkg::PH_SP0: begin s.drv = 1'b1; s.sda = 1'b0; end
            i2cram_pkg::PH_SP1: s.scl = 1'b1;
            i2cram_pkg::PH_SP2: s.sda = 1'b1;
            i2cram_pkg::PH_SP3: s.scl = 1'b1;
            default: ;
        endcase
        return s;
    endfunction

    // Pick the next byte to send, or turn around / stop after an ACK clock
    function automatic i2cram_pkg::t_core_state after_sent(input i2cram_pkg::t_core_state st);
        i2cram_pkg::t_core_state s;
        logic [2:0] sel;
        s = st;
        s.drv = 1'b1;
        sel = 3'd0;
        if (!s.ok) begin
            s = enter(s, i2cram_pkg::PH_SP0);
        end else if (!s.read_mode) begin
            s.byte_pos = s.byte_pos + 4'd1;
            sel = s.byte_pos[2:0] - 3'd2;
            if (s.byte_pos == 4'd1) begin
                s.shreg = s.index;
                s.bit_pos = 3'd7;
                s = enter(s, i2cram_pkg::PH_TXA);
            end else if (s.byte_pos >= 4'd2 &&
                         {1'b0, s.byte_pos} < ({1'b0, s.count} + 5'd2)) begin
                s.shreg = s.data[{sel, 3'b000} +: 8];
                s.bit_pos = 3'd7;
                s = enter(s, i2cram_pkg::PH_TXA);
            end else begin
                s = enter(s, i2cram_pkg::PH_SP0);
            end
        end else if (s.byte_pos == 4'd0) begin
            s.byte_pos = 4'd1;
            s.shreg = s.index;
            s.bit_pos = 3'd7;
            s = enter(s, i2cram_pkg::PH_TXA);
        end else if (s.byte_pos == 4'd1) begin
            s.byte_pos = 4'd2;
            s.shreg = s.addr | i2cram_pkg::ADDR_RD_BIT;
            s = enter(s, i2cram_pkg::PH_ST0);
        end else begin
            s.byte_pos = 4'd0;
            s.shreg = 8'd0;
            s.bit_pos = 3'd7;
            s = enter(s, i2cram_pkg::PH_RXA);
        end
        return s;
    endfunction

    function automatic i2cram_pkg::t_core_state end_phase(input i2cram_pkg::t_core_state st,
                                                          input logic sda);
        i2cram_pkg::t_core_state s;
        s = st;
        case (s.phase)
            i2cram_pkg::PH_ST0: s = enter(s, i2cram_pkg::PH_ST1);
            i2cram_pkg::PH_ST1: s = enter(s, i2cram_pkg::PH_ST2);
            i2cram_pkg::PH_ST2: s = enter(s, i2cram_pkg::PH_ST3);
            i2cram_pkg::PH_ST3: begin
                s.bit_pos = 3'd7;
                s = enter(s, i2cram_pkg::PH_TXA);
            end
            i2cram_pkg::PH_TXA: s = enter(s, i2cram_pkg::PH_TXB);
            i2cram_pkg::PH_TXB: s = enter(s, i2cram_pkg::PH_TXC);
            i2cram_pkg::PH_TXC: begin
                if (s.bit_pos == 3'd0) begin
                    s = enter(s, i2cram_pkg::PH_TKA);
                end else begin
                    s.bit_pos = s.bit_pos - 3'd1;
                    s = enter(s, i2cram_pkg::PH_TXA);
                end
            end
            i2cram_pkg::PH_TKA: s = enter(s, i2cram_pkg::PH_TKB);
            i2cram_pkg::PH_TKB: begin
                if (sda) s.ok = 1'b0;
                s = enter(s, i2cram_pkg::PH_TKC);
            end
            i2cram_pkg::PH_TKC: s = after_sent(s);
            i2cram_pkg::PH_RXA: s = enter(s, i2cram_pkg::PH_RXB);
            i2cram_pkg::PH_RXB: begin
                s.shreg = {s.shreg[6:0], sda};
                s = enter(s, i2cram_pkg::PH_RXC);
            end
            i2cram_pkg::PH_RXC: begin
                if (s.bit_pos == 3'd0) begin
                    s = enter(s, i2cram_pkg::PH_RKA);
                end else begin
                    s.bit_pos = s.bit_pos - 3'd1;
                    s = enter(s, i2cram_pkg::PH_RXA);
                end
            end
            i2cram_pkg::PH_RKA: s = enter(s, i2cram_pkg::PH_RKB);
            i2cram_pkg::PH_RKB: s = enter(s, i2cram_pkg::PH_RKC);
            i2cram_pkg::PH_RKC: s = enter(s, i2cram_pkg::PH_RKD);
            i2cram_pkg::PH_RKD: begin
                s.byte_pos = s.byte_pos + 4'd1;
                if (s.byte_pos < s.count) begin
                    s.shreg = 8'd0;
                    s.bit_pos = 3'd7;
                    s = enter(s, i2cram_pkg::PH_RXA);
                end else begin
                    s = enter(s, i2cram_pkg::PH_SP0);
                end
            end
            i2cram_pkg::PH_SP0: s = enter(s, i2cram_pkg::PH_SP1);
            i2cram_pkg::PH_SP1: s = enter(s, i2cram_pkg::PH_SP2);
            i2cram_pkg::PH_SP2: s = enter(s, i2cram_pkg::PH_SP3);
            i2cram_pkg::PH_SP3: s.phase = i2cram_pkg::PH_IDLE;
            default:            s.phase = i2cram_pkg::PH_IDLE;
        endcase
        return s;
    endfunction

    logic        idle;
    logic        is_cmd;
    logic        is_tick;
    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic        phase_end;
    logic [3:0]  cnt_sat;

    assign idle      = (i_state.phase == i2cram_pkg::PH_IDLE);
    assign is_cmd    = (i_req.action == i2cram_pkg::ACT_WRITE) ||
                       (i_req.action == i2cram_pkg::ACT_READ);
    assign is_tick   = (i_req.action == i2cram_pkg::ACT_TICK) && !idle;
    assign tick_inc  = i_state.tick + 16'd1;
    assign limit     = (i_ticks == 16'd0) ? 16'd1 : i_ticks;
    assign phase_end = is_tick && (tick_inc >= limit);

    always_comb begin
        if (i_req.byte_count > 4'(i2cram_pkg::MAX_BYTES)) begin
            cnt_sat = 4'(i2cram_pkg::MAX_BYTES);
        end else if (i_req.action == i2cram_pkg::ACT_READ && i_req.byte_count == 4'd0) begin
            cnt_sat = 4'd1;
        end else begin
            cnt_sat = i_req.byte_count;
        end
    end

    // Next state
    always_comb begin
        o_next = i_state;
        if (is_cmd && idle) begin
            o_next.read_mode = (i_req.action == i2cram_pkg::ACT_READ);
            o_next.addr      = i_req.device_address;
            o_next.index     = i_req.register_index;
            o_next.data      = i_req.write_data;
            o_next.count     = cnt_sat;
            o_next.ok        = 1'b1;
            o_next.byte_pos  = 4'd0;
            o_next.bit_pos   = 3'd7;
            o_next.shreg     = i_req.device_address & i2cram_pkg::ADDR_WR_MASK;
            o_next.tick      = 16'd0;
            o_next           = enter(o_next, i2cram_pkg::PH_ST0);
        end else if (is_tick) begin
            if (phase_end) begin
                o_next.tick = 16'd0;
                o_next      = end_phase(o_next, i_req.sda_in);
            end else begin
                o_next.tick = tick_inc;
            end
        end
    end

    // Result fields
    always_comb begin
        o_result.scl_level  = o_next.scl;
        o_result.sda_level  = o_next.sda;
        o_result.sda_drive  = o_next.drv;
        o_result.busy_res   = (o_next.phase != i2cram_pkg::PH_IDLE);
        o_result.read_valid = phase_end && (i_state.phase == i2cram_pkg::PH_RKD);
        o_result.read_byte  = o_result.read_valid ? i_state.shreg : 8'd0;
        o_result.done_res   = phase_end && (i_state.phase == i2cram_pkg::PH_SP3);
        o_result.success    = o_result.done_res && i_state.ok;
    end

endmodule

`default_nettype wire

FILE: src/i2c_register_access_master_core.sv
// Top level of the I2C register access master: request stream in, pin/status stream out.
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while each result is taken; the sequencer state
//   and the output register both update in the cycle a request is accepted, and the
//   output register frees the input side whenever the downstream takes its result.
// Reset: synchronous, active low; the sequencer goes idle with SCL high and SDA
//   released, the phase length returns to 6 ticks, and the output register empties.

module i2c_register_access_master_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // phase length register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata, low bit up: device_address[7:0], register_index[15:8], byte_count[19:16],
    //   write_data[83:20], sda_in[84], zero pad[87:85]
    input  wire logic [87:0] i_s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata, low bit up: scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
    //   read_byte[11:4], read_valid[12], done_res[13], success[14], zero pad[15]
    output logic [15:0]      o_m_axis_tdata
);

    i2cram_pkg::t_core_state r_state;
    i2cram_pkg::t_core_state n_state;
    i2cram_pkg::t_result     r_out;
    i2cram_pkg::t_result     n_out;
    i2cram_pkg::t_request    req;
    logic [15:0]             r_ticks;
    logic                    r_out_valid;
    logic                    s_acc;

    // Unpack the request fields
    assign req.action         = i_s_axis_tuser;
    assign req.device_address = i_s_axis_tdata[7:0];
    assign req.register_index = i_s_axis_tdata[15:8];
    assign req.byte_count     = i_s_axis_tdata[19:16];
    assign req.write_data     = i_s_axis_tdata[83:20];
    assign req.sda_in         = i_s_axis_tdata[84];

    // Take a new request whenever the result slot is empty or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    i2cram_step u_step (
        .i_state  (r_state),
        .i_req    (req),
        .i_ticks  (r_ticks),
        .o_next   (n_state),
        .o_result (n_out)
    );

    // Phase length register; a write applies from the next tick on, even mid-phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= i2cram_pkg::TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_ticks <= i_cfg_wr_data;
        end
    end

    // Advance the sequencer on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= i2cram_pkg::PH_IDLE;
            r_state.tick      <= 16'd0;
            r_state.bit_pos   <= 3'd0;
            r_state.byte_pos  <= 4'd0;
            r_state.shreg     <= 8'd0;
            r_state.read_mode <= 1'b0;
            r_state.ok        <= 1'b1;
            r_state.addr      <= 8'd0;
            r_state.index     <= 8'd0;
            r_state.data      <= 64'd0;
            r_state.count     <= 4'd0;
            r_state.scl       <= 1'b1;
            r_state.sda       <= 1'b1;
            r_state.drv       <= 1'b0;
        end else if (s_acc) begin
            r_state <= n_state;
        end
    end

    // Result register: fill on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.success, r_out.done_res, r_out.read_valid,
                              r_out.read_byte, r_out.busy_res, r_out.sda_drive,
                              r_out.sda_level, r_out.scl_level};

    // A pending result that is not taken must block the input side
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("request accepted while result is stalled");

    // A finished stop leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // A received byte and the end of the stop never fall on the same tick
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.read_valid && r_out.done_res))
        else $error("read_valid and done in one result");

    // Idle bus always rests with SCL and SDA high
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == i2cram_pkg::PH_IDLE |-> r_state.scl && r_state.sda)
        else $error("idle bus not released high");

endmodule

`default_nettype wire

FILE: tb/sv/i2c_register_access_master_core_test.sv
// Self-checking testbench of the I2C register access master core.
`timescale 1ns / 1ps

module i2c_register_access_master_core_test;
    import i2cram_pkg::*;

    localparam int         CLK_PERIOD = 12;
    localparam logic [1:0] ACT_NOP    = 2'd3;   // action code the core ignores
    localparam int         RANDOM_ITEMS = 200;

    // Bit-accurate prediction of the pin sequencer plus the queue of results it owes.
    class i2c_pin_predictor;
        logic [15:0] phase_ticks;
        t_phase      phase;
        logic [15:0] tick_cnt;
        logic [3:0]  bit_pos;
        logic [3:0]  byte_pos;
        logic [7:0]  shreg;
        logic        rd_mode;
        logic        ack_ok;
        logic [7:0]  addr;
        logic [7:0]  index;
        logic [63:0] data;
        logic [3:0]  count;
        logic        scl;
        logic        sda;
        logic        drv;
        t_result     step_out;
        t_result     expected_pins[$];
        int          errors;

        function new();
            phase_ticks = TICKS_RESET;
            phase       = PH_IDLE;
            tick_cnt    = '0;
            bit_pos     = '0;
            byte_pos    = '0;
            shreg       = '0;
            rd_mode     = 1'b0;
            ack_ok      = 1'b1;
            addr        = '0;
            index       = '0;
            data        = '0;
            count       = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            drv         = 1'b0;
            errors      = 0;
        endfunction

        // Set the pins on entry to a phase.
        function void enter_phase(t_phase ph);
            phase = ph;
            case (ph)
                PH_ST0: begin
                    drv = 1'b1;
                    sda = 1'b1;
                end
                PH_ST1: scl = 1'b1;
                PH_ST2: sda = 1'b0;
                PH_ST3: scl = 1'b0;
                PH_TXA: scl = 1'b0;
                PH_TXB: sda = shreg[bit_pos[2:0]];
                PH_TXC: scl = 1'b1;
                PH_TKA, PH_RXA: begin
                    drv = 1'b0;
                    scl = 1'b0;
                end
                PH_TKB: scl = 1'b1;
                PH_TKC: scl = 1'b0;
                PH_RXB: scl = 1'b1;
                PH_RKA: scl = 1'b0;
                PH_RKB: begin
                    // NAK the last byte, ACK the others
                    drv = 1'b1;
                    sda = (int'(byte_pos) + 1 >= int'(count));
                end
                PH_RKC: scl = 1'b1;
                PH_RKD: scl = 1'b0;
                PH_SP0: begin
                    drv = 1'b1;
                    sda = 1'b0;
                end
                PH_SP1: scl = 1'b1;
                PH_SP2: sda = 1'b1;
                PH_SP3: scl = 1'b1;
                default: ;
            endcase
        endfunction

        // Pick the next byte, the repeated start, the receive or the stop after an ACK slot.
        function void after_sent_byte();
            int lane;
            drv = 1'b1;
            if (!ack_ok) begin
                enter_phase(PH_SP0);
                return;
            end
            if (!rd_mode) begin
                byte_pos = byte_pos + 4'd1;
                if (byte_pos == 4'd1) begin
                    shreg = index;
                end else if (byte_pos >= 4'd2 && int'(byte_pos) < int'(count) + 2) begin
                    lane  = (int'(byte_pos) - 2) & 7;
                    shreg = data[8*lane +: 8];
                end else begin
                    enter_phase(PH_SP0);
                    return;
                end
                bit_pos = 4'd7;
                enter_phase(PH_TXA);
            end else if (byte_pos == 4'd0) begin
                byte_pos = 4'd1;
                shreg    = index;
                bit_pos  = 4'd7;
                enter_phase(PH_TXA);
            end else if (byte_pos == 4'd1) begin
                byte_pos = 4'd2;
                shreg    = addr | ADDR_RD_BIT;
                enter_phase(PH_ST0);
            end else begin
                byte_pos = 4'd0;
                shreg    = '0;
                bit_pos  = 4'd7;
                enter_phase(PH_RXA);
            end
        endfunction

        // Advance the sequencer at the tick that ends the current phase.
        function void finish_phase(logic sda_in);
            case (phase)
                PH_ST0: enter_phase(PH_ST1);
                PH_ST1: enter_phase(PH_ST2);
                PH_ST2: enter_phase(PH_ST3);
                PH_ST3: begin
                    bit_pos = 4'd7;
                    enter_phase(PH_TXA);
                end
                PH_TXA: enter_phase(PH_TXB);
                PH_TXB: enter_phase(PH_TXC);
                PH_TXC: begin
                    if (bit_pos == 4'd0) begin
                        enter_phase(PH_TKA);
                    end else begin
                        bit_pos = bit_pos - 4'd1;
                        enter_phase(PH_TXA);
                    end
                end
                PH_TKA: enter_phase(PH_TKB);
                PH_TKB: begin
                    if (sda_in) ack_ok = 1'b0;
                    enter_phase(PH_TKC);
                end
                PH_TKC: after_sent_byte();
                PH_RXA: enter_phase(PH_RXB);
                PH_RXB: begin
                    shreg = {shreg[6:0], sda_in};
                    enter_phase(PH_RXC);
                end
                PH_RXC: begin
                    if (bit_pos == 4'd0) begin
                        enter_phase(PH_RKA);
                    end else begin
                        bit_pos = bit_pos - 4'd1;
                        enter_phase(PH_RXA);
                    end
                end
                PH_RKA: enter_phase(PH_RKB);
                PH_RKB: enter_phase(PH_RKC);
                PH_RKC: enter_phase(PH_RKD);
                PH_RKD: begin
                    step_out.read_valid = 1'b1;
                    step_out.read_byte  = shreg;
                    byte_pos = byte_pos + 4'd1;
                    if (byte_pos < count) begin
                        shreg   = '0;
                        bit_pos = 4'd7;
                        enter_phase(PH_RXA);
                    end else begin
                        enter_phase(PH_SP0);
                    end
                end
                PH_SP0: enter_phase(PH_SP1);
                PH_SP1: enter_phase(PH_SP2);
                PH_SP2: enter_phase(PH_SP3);
                PH_SP3: begin
                    step_out.done_res = 1'b1;
                    step_out.success  = ack_ok;
                    phase = PH_IDLE;
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        // Apply one accepted request and queue the result it owes.
        function void note_request(t_request r);
            logic [3:0]  n;
            logic [15:0] limit;
            step_out = '0;
            if (r.action == ACT_WRITE || r.action == ACT_READ) begin
                // commands while busy are dropped
                if (phase == PH_IDLE) begin
                    n       = r.byte_count;
                    rd_mode = (r.action == ACT_READ);
                    addr    = r.device_address;
                    index   = r.register_index;
                    data    = r.write_data;
                    if (n > MAX_BYTES) n = 4'(MAX_BYTES);
                    if (rd_mode && n == 4'd0) n = 4'd1;
                    count    = n;
                    ack_ok   = 1'b1;
                    byte_pos = '0;
                    bit_pos  = 4'd7;
                    shreg    = addr & ADDR_WR_MASK;
                    tick_cnt = '0;
                    enter_phase(PH_ST0);
                end
            end else if (r.action == ACT_TICK && phase != PH_IDLE) begin
                limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= limit) begin
                    tick_cnt = '0;
                    finish_phase(r.sda_in);
                end
            end
            step_out.scl_level = scl;
            step_out.sda_level = sda;
            step_out.sda_drive = drv;
            step_out.busy_res  = (phase != PH_IDLE);
            expected_pins.push_back(step_out);
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        endfunction

        // Compare one delivered result with the oldest one owed.
        function void check_result(t_result got);
            t_result want;
            if (expected_pins.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = expected_pins.pop_front();
            if (got.scl_level !== want.scl_level)
                report_field("scl_level", want.scl_level, got.scl_level);
            if (got.sda_level !== want.sda_level)
                report_field("sda_level", want.sda_level, got.sda_level);
            if (got.sda_drive !== want.sda_drive)
                report_field("sda_drive", want.sda_drive, got.sda_drive);
            if (got.busy_res !== want.busy_res)
                report_field("busy_res", want.busy_res, got.busy_res);
            if (got.read_byte !== want.read_byte)
                report_field("read_byte", want.read_byte, got.read_byte);
            if (got.read_valid !== want.read_valid)
                report_field("read_valid", want.read_valid, got.read_valid);
            if (got.done_res !== want.done_res)
                report_field("done_res", want.done_res, got.done_res);
            if (got.success !== want.success)
                report_field("success", want.success, got.success);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [87:0] i_s_axis_tdata = '0;   // device_address, register_index, byte_count,
                                        // write_data, sda_in, zero pad
    logic [1:0]  i_s_axis_tuser = '0;   // action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // scl, sda, drive, busy, read_byte, read_valid,
                                        // done, success, zero pad

    i2c_pin_predictor pins;

    logic        force_nak = 1'b0;      // slave refuses every byte while set
    int          burst_left = 0;
    int          items_done = 0;
    logic [15:0] stall_pattern = '1;
    logic [31:0] rx_cycle = '0;

    i2c_register_access_master_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stall the result side on a pattern redrawn whenever rx_cycle[5:0] is zero:
    // sometimes never, sometimes sparse, sometimes mostly stalled.
    always @(posedge i_clk) begin
        if (rx_cycle[5:0] == 6'd0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= '1;
                1: stall_pattern <= 16'($urandom);
                2: stall_pattern <= 16'($urandom) | 16'($urandom);
                default: stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
        end
        i_m_axis_tready <= stall_pattern[rx_cycle[3:0]];
        rx_cycle <= rx_cycle + 32'd1;
    end

    function automatic t_result unpack_pins(logic [15:0] d);
        t_result p;
        p.scl_level  = d[0];
        p.sda_level  = d[1];
        p.sda_drive  = d[2];
        p.busy_res   = d[3];
        p.read_byte  = d[11:4];
        p.read_valid = d[12];
        p.done_res   = d[13];
        p.success    = d[14];
        return p;
    endfunction

    // Check every result taken from the core.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            pins.check_result(unpack_pins(o_m_axis_tdata));
    end

    // Play the slave: ACK sent bytes (with a rare NAK), random bits elsewhere.
    function automatic logic next_sda();
        if (pins.phase == PH_TKB)
            return force_nak || ($urandom_range(0, 29) == 0);
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_request random_item(logic [1:0] act);
        t_request r;
        r.action         = act;
        r.device_address = 8'($urandom);
        r.register_index = 8'($urandom);
        r.byte_count     = 4'($urandom);
        r.write_data     = {$urandom, $urandom};
        r.sda_in         = next_sda();
        return r;
    endfunction

    // Present one request, sometimes idling first at the start of a burst, and hold it until taken.
    task automatic send_request(input t_request r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, r.sda_in, r.write_data, r.byte_count,
                            r.register_index, r.device_address};
        i_s_axis_tuser  <= r.action;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pins.note_request(r);
    endtask

    task automatic issue_command(input logic [1:0] act, input logic [7:0] a,
                                 input logic [7:0] idx, input logic [3:0] n,
                                 input logic [63:0] d);
        t_request r;
        r = random_item(act);
        r.device_address = a;
        r.register_index = idx;
        r.byte_count     = n;
        r.write_data     = d;
        send_request(r);
    endtask

    // Tick until the transfer ends; drop in the odd ignored command.
    task automatic run_to_idle();
        t_request r;
        while (pins.phase != PH_IDLE) begin
            r = random_item(ACT_TICK);
            if ($urandom_range(0, 39) == 0)
                r.action = 2'($urandom_range(1, 3));
            send_request(r);
            if (r.action == ACT_TICK) items_done++;
        end
    endtask

    // Drain the result side, then write the phase length.
    task automatic set_phase_ticks(input logic [15:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (pins.expected_pins.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        pins.phase_ticks = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [3:0] n;
        logic [1:0] act;
        int         pick;
        int         spins;

        pins = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle requests: tick and no-op do nothing.
        send_request(random_item(ACT_TICK));
        send_request(random_item(ACT_NOP));

        // Zero phase length behaves as one tick.
        set_phase_ticks(16'd0);

        // Write with no data bytes; commands and no-ops while busy are dropped.
        issue_command(ACT_WRITE, 8'hFF, 8'h00, 4'd0, 64'd0);
        send_request(random_item(ACT_READ));
        send_request(random_item(ACT_WRITE));
        send_request(random_item(ACT_NOP));
        run_to_idle();

        // Oversized count saturates to the byte limit.
        issue_command(ACT_WRITE, 8'h00, 8'hFF, 4'd15, '1);
        run_to_idle();

        set_phase_ticks(16'd1);

        // Read count zero becomes one byte; then a full-length read.
        issue_command(ACT_READ, 8'h5A, 8'h00, 4'd0, 64'd0);
        run_to_idle();
        issue_command(ACT_READ, 8'hA5, 8'h3C, 4'd8, 64'hA5A5_5A5A_0F0F_F0F0);
        run_to_idle();

        // Slave NAK on the address ends each transfer with success low.
        force_nak = 1'b1;
        issue_command(ACT_WRITE, 8'h42, 8'h10, 4'd2, 64'h0123_4567_89AB_CDEF);
        run_to_idle();
        issue_command(ACT_READ, 8'h43, 8'h11, 4'd3, 64'd0);
        run_to_idle();
        force_nak = 1'b0;

        // Longest phase: park mid-phase, then shorten the phase under a live count.
        set_phase_ticks(16'hFFFF);
        issue_command(ACT_READ, 8'h81, 8'h7E, 4'd1, 64'd0);
        repeat (150) send_request(random_item(ACT_TICK));
        set_phase_ticks(16'd1);
        run_to_idle();

        // Random transfers under changing phase lengths.
        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0: set_phase_ticks(16'd0);
                    1, 2, 3, 4: set_phase_ticks(16'd1);
                    5: set_phase_ticks(16'd6);
                    default: set_phase_ticks(16'($urandom_range(2, 4)));
                endcase
            end
            // idle noise
            repeat ($urandom_range(0, 2))
                send_request(random_item(($urandom_range(0, 1) == 0) ? ACT_TICK : ACT_NOP));
            pick = $urandom_range(0, 19);
            if (pick < 15)      n = 4'($urandom_range(0, 3));
            else if (pick < 19) n = 4'($urandom_range(4, 8));
            else                n = 4'($urandom_range(9, 15));
            act = ($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_READ;
            issue_command(act, 8'($urandom), 8'($urandom), n, {$urandom, $urandom});
            items_done++;
            run_to_idle();
        end

        // Wait for the last results, then idle before the final report.
        i_s_axis_tvalid <= 1'b0;
        spins = 0;
        while (pins.expected_pins.size() != 0 && spins < 5000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (4) @(posedge i_clk);
        if (pins.expected_pins.size() != 0) begin
            pins.errors++;
            $display("%0t: missing results, expected %0d more, got none",
                     $time, pins.expected_pins.size());
        end
        if (pins.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
